### src/fct_pkg.sv
package fct_pkg;

    localparam int DEFAULT_ENTRY_COUNT = 3072;

    // table marks
    localparam logic [11:0] MARK_RESERVED = 12'hFF0;
    localparam logic [11:0] MARK_END      = 12'hFF8;
    localparam logic [11:0] MARK_FREE     = 12'h000;

    // command codes
    localparam logic [2:0] CMD_READ   = 3'd0;
    localparam logic [2:0] CMD_WRITE  = 3'd1;
    localparam logic [2:0] CMD_ALLOC  = 3'd2;
    localparam logic [2:0] CMD_FREE   = 3'd3;
    localparam logic [2:0] CMD_PACKED = 3'd4;

    // status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_RANGE  = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;
    localparam logic [1:0] STAT_BROKEN = 2'd3;

    // floor(n / 3) = (n * DIV3_MUL) >> DIV3_SHIFT for any 13-bit n
    localparam logic [11:0] DIV3_MUL   = 12'd2731;
    localparam int          DIV3_SHIFT = 13;

    typedef struct packed {
        logic [2:0]  command;
        logic [11:0] entry_index;
        logic [11:0] new_value;
        logic        link_previous;
        logic [12:0] byte_offset;
    } req_item_t;

    typedef struct packed {
        logic [11:0] entry_value;
        logic [11:0] allocated_index;
        logic [7:0]  packed_byte;
        logic [1:0]  status;
    } rsp_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_RD_WAIT,
        ST_SCAN,
        ST_LINK,
        ST_FR_EVAL,
        ST_FR_READ,
        ST_PK_LO,
        ST_PK_HI,
        ST_PK_SEL,
        ST_RESP
    } state_t;

endpackage

### src/fat12_chain_table_engine.sv
// FAT12-style chain table engine.
//
// Channels: a request beat (req, req_valid/req_ready) carries one command:
// read entry, write entry, allocate, free chain or read packed byte. Each
// request yields exactly one response beat (rsp, rsp_valid/rsp_ready).
// The table lives in one single-port-read, single-port-write synchronous RAM
// of ENTRY_COUNT twelve-bit entries; all table access goes through that RAM.
//
// Work per command, request accept to response valid (one RAM read per cycle):
//   write, unknown command, range errors : answered without a RAM read
//   read entry                           : one RAM read
//   read packed byte                     : two RAM reads (the entry pair)
//   allocate                             : scan from entry 0 up to the first
//                                          free index, plus one link write if
//                                          the previous entry is linked; a full
//                                          table is scanned to its last entry
//   free chain                           : one read and one write per entry walked
// One request is in work at a time; a new request is taken once the
// previous result sits in the output register.
//
// Reset: after rst_n releases, a clearing pass writes every entry (0xFF0 to
// entries 0 and 1, free elsewhere), ENTRY_COUNT cycles, with req_ready low.
// Stall: if rsp_ready stays low, the finished result holds in the output
// register and the engine waits before loading the next one.
module fat12_chain_table_engine
    import fct_pkg::*;
#(
    parameter int ENTRY_COUNT = DEFAULT_ENTRY_COUNT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  req_item_t req,
    input  logic      req_valid,
    output logic      req_ready,
    output rsp_item_t rsp,
    output logic      rsp_valid,
    input  logic      rsp_ready
);

    localparam int          AW           = $clog2(ENTRY_COUNT);
    localparam int          PACKED_BYTES = 3 * ENTRY_COUNT / 2;
    localparam logic [11:0] EC12         = 12'(ENTRY_COUNT);
    localparam logic [12:0] EC13         = 13'(ENTRY_COUNT);
    localparam logic [12:0] PB13         = 13'(PACKED_BYTES);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(ENTRY_COUNT - 1);

    // table RAM
    logic [11:0]   mem [ENTRY_COUNT];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [11:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [11:0]   mem_rdata_reg;

    state_t        state_reg, state_next;
    logic [AW-1:0] clr_reg;
    req_item_t     req_reg;
    rsp_item_t     res_reg;
    rsp_item_t     rsp_reg;
    logic          rsp_valid_reg;
    logic [AW-1:0] scan_addr_reg;
    logic [AW-1:0] chk_addr_reg;
    logic          chk_vld_reg;
    logic [AW-1:0] cur_reg;
    logic [11:0]   pair_reg;
    logic [1:0]    rem_reg;
    logic [11:0]   lo_reg;
    logic          hi_ok_reg;

    logic          idx_ok;
    logic          off_ok;
    logic [24:0]   div_prod;
    logic [12:0]   lo_idx;
    logic [12:0]   hi_idx;
    logic [13:0]   rem_full;
    logic          scan_hit;
    logic          scan_last;
    logic          rd_is_end;
    logic          rd_is_link;
    logic          rsp_free;
    logic [11:0]   hi_val;
    logic [7:0]    byte_sel;

    assign idx_ok     = req_reg.entry_index < EC12;
    assign off_ok     = req_reg.byte_offset < PB13;
    assign div_prod   = req_reg.byte_offset * DIV3_MUL;
    assign lo_idx     = {pair_reg, 1'b0};
    assign hi_idx     = {pair_reg, 1'b1};
    assign rem_full   = {1'b0, req_reg.byte_offset} - ({1'b0, lo_idx} + {2'b00, pair_reg});
    assign scan_hit   = chk_vld_reg && (mem_rdata_reg == MARK_FREE);
    assign scan_last  = chk_vld_reg && (chk_addr_reg == LAST_ADDR);
    assign rd_is_end  = mem_rdata_reg >= MARK_END;
    assign rd_is_link = (mem_rdata_reg >= 12'd2) && (mem_rdata_reg < EC12)
                        && (mem_rdata_reg < MARK_RESERVED);
    assign rsp_free   = !rsp_valid_reg || rsp_ready;
    assign hi_val     = hi_ok_reg ? mem_rdata_reg : MARK_FREE;

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    // pick the packed byte from the entry pair
    always_comb
    begin
        case (rem_reg)
            2'd0:    byte_sel = lo_reg[11:4];
            2'd1:    byte_sel = {lo_reg[3:0], hi_val[11:8]};
            2'd2:    byte_sel = hi_val[7:0];
            default: byte_sel = 8'd0;
        endcase
    end

    // RAM: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (req_reg.command)
                    CMD_READ:   state_next = idx_ok ? ST_RD_WAIT : ST_RESP;
                    CMD_ALLOC:  state_next = (req_reg.link_previous && !idx_ok) ?
                                             ST_RESP : ST_SCAN;
                    CMD_FREE:   state_next = idx_ok ? ST_FR_EVAL : ST_RESP;
                    CMD_PACKED: state_next = off_ok ? ST_PK_LO : ST_RESP;
                    default:    state_next = ST_RESP;
                endcase
            end
            ST_RD_WAIT:
            begin
                state_next = ST_RESP;
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = req_reg.link_previous ? ST_LINK : ST_RESP;
                end
                else if (scan_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_LINK:
            begin
                state_next = ST_RESP;
            end
            ST_FR_EVAL:
            begin
                state_next = (!rd_is_end && rd_is_link) ? ST_FR_READ : ST_RESP;
            end
            ST_FR_READ:
            begin
                state_next = ST_FR_EVAL;
            end
            ST_PK_LO:
            begin
                state_next = ST_PK_HI;
            end
            ST_PK_HI:
            begin
                state_next = ST_PK_SEL;
            end
            ST_PK_SEL:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // RAM controls and request handshake
    always_comb
    begin
        req_ready = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = MARK_FREE;
        mem_re    = 1'b0;
        mem_raddr = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = (clr_reg < AW'(2)) ? MARK_RESERVED : MARK_FREE;
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            ST_DISPATCH:
            begin
                if (idx_ok)
                begin
                    unique case (req_reg.command)
                        CMD_WRITE:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = req_reg.entry_index[AW-1:0];
                            mem_wdata = req_reg.new_value;
                        end
                        CMD_READ, CMD_FREE:
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = req_reg.entry_index[AW-1:0];
                        end
                        default:
                        begin
                            mem_re = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = chk_addr_reg;
                    mem_wdata = MARK_END;
                end
                else if (!scan_last)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = scan_addr_reg;
                end
            end
            ST_LINK:
            begin
                mem_we    = 1'b1;
                mem_waddr = req_reg.entry_index[AW-1:0];
                mem_wdata = 12'(chk_addr_reg);
            end
            ST_FR_EVAL:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur_reg;
                mem_wdata = MARK_FREE;
            end
            ST_FR_READ:
            begin
                mem_re    = 1'b1;
                mem_raddr = cur_reg;
            end
            ST_PK_LO:
            begin
                mem_re    = 1'b1;
                mem_raddr = lo_idx[AW-1:0];
            end
            ST_PK_HI:
            begin
                mem_re    = hi_idx < EC13;
                mem_raddr = hi_idx[AW-1:0];
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            chk_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (state_reg == ST_RESP && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (state_reg == ST_DISPATCH)
            begin
                chk_vld_reg <= 1'b0;
            end
            else if (state_reg == ST_SCAN && !scan_hit && !scan_last)
            begin
                chk_vld_reg <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_reg <= req;
                    res_reg <= '0;
                end
            end
            ST_DISPATCH:
            begin
                scan_addr_reg <= '0;
                cur_reg       <= req_reg.entry_index[AW-1:0];
                pair_reg      <= div_prod[DIV3_SHIFT +: 12];
                case (req_reg.command)
                    CMD_READ, CMD_WRITE, CMD_FREE:
                    begin
                        if (!idx_ok)
                        begin
                            res_reg.status <= STAT_RANGE;
                        end
                    end
                    CMD_ALLOC:
                    begin
                        if (req_reg.link_previous && !idx_ok)
                        begin
                            res_reg.status <= STAT_RANGE;
                        end
                    end
                    CMD_PACKED:
                    begin
                        if (!off_ok)
                        begin
                            res_reg.status <= STAT_RANGE;
                        end
                    end
                    default:
                    begin
                        res_reg.status <= STAT_OK;
                    end
                endcase
            end
            ST_RD_WAIT:
            begin
                res_reg.entry_value <= mem_rdata_reg;
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    res_reg.allocated_index <= 12'(chk_addr_reg);
                end
                else if (scan_last)
                begin
                    res_reg.status <= STAT_FULL;
                end
                else
                begin
                    chk_addr_reg  <= scan_addr_reg;
                    scan_addr_reg <= scan_addr_reg + AW'(1);
                end
            end
            ST_FR_EVAL:
            begin
                // judge the link after the entry has been freed
                if (rd_is_end)
                begin
                    res_reg.status <= STAT_OK;
                end
                else if (!rd_is_link)
                begin
                    res_reg.status <= STAT_BROKEN;
                end
                else
                begin
                    cur_reg <= mem_rdata_reg[AW-1:0];
                end
            end
            ST_PK_LO:
            begin
                rem_reg <= rem_full[1:0];
            end
            ST_PK_HI:
            begin
                lo_reg    <= mem_rdata_reg;
                hi_ok_reg <= hi_idx < EC13;
            end
            ST_PK_SEL:
            begin
                res_reg.packed_byte <= byte_sel;
            end
            ST_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_reg <= res_reg;
                end
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    // never read and write the same entry in one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("RAM read and write collide");

    // a new response only ever comes out of the response state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> ($past(state_reg) == ST_RESP))
        else $error("response raised outside response state");

    // a full table gives out no index
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == STAT_FULL) |-> (rsp.allocated_index == 12'd0))
        else $error("full table reported with an index");

    // scanning stays inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && chk_vld_reg) |-> (12'(chk_addr_reg) < EC12))
        else $error("scan beyond table");

endmodule

### verif/tb_fat12_chain_table_engine.sv
`timescale 1ns / 1ps

module tb_fat12_chain_table_engine;
    import fct_pkg::*;

    localparam int ENTRY_COUNT  = DEFAULT_ENTRY_COUNT;
    localparam int PACKED_BYTES = 3 * ENTRY_COUNT / 2;
    // Longest quiet stretch a correct block can show: a free walk over the
    // whole table or the clearing pass; take that several times over.
    localparam int QUIET_LIMIT  = 10 * ENTRY_COUNT + 2000;
    localparam int TAIL_CYCLES  = 50;
    localparam int LONG_CHAIN   = 64;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    req_item_t req = '0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    rsp_item_t rsp;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;

    // Commands waiting to be driven, and replies predicted for accepted beats.
    req_item_t   command_backlog [$];
    rsp_item_t   expected_replies [$];
    int          queued_count = 0;

    // Our own copy of the allocation table, advanced at every accepted beat.
    logic [11:0] fat_mirror [ENTRY_COUNT];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count = 0;
    int quiet_cycles = 0;

    fat12_chain_table_engine DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Entries past the end of the table read as zero in the packed image.
    function automatic logic [11:0] mirror_entry(int idx);
        if (idx >= ENTRY_COUNT)
            return MARK_FREE;
        return fat_mirror[idx];
    endfunction

    // Apply one command to the mirror and return the reply it must produce.
    function automatic rsp_item_t run_fat_command(req_item_t r);
        rsp_item_t   res;
        int          idx;
        int          cur;
        int          first_free;
        int          i;
        int          pair;
        bit          in_range;
        bit          walking;
        logic [11:0] next_link;
        logic [11:0] lo_e;
        logic [11:0] hi_e;
        res = '0;
        idx = int'(r.entry_index);
        in_range = idx < ENTRY_COUNT;
        case (r.command)
            CMD_READ:
            begin
                if (in_range)
                    res.entry_value = fat_mirror[idx];
                else
                    res.status = STAT_RANGE;
            end
            CMD_WRITE:
            begin
                if (in_range)
                    fat_mirror[idx] = r.new_value;
                else
                    res.status = STAT_RANGE;
            end
            CMD_ALLOC:
            begin
                if (r.link_previous && !in_range)
                begin
                    res.status = STAT_RANGE;
                end
                else
                begin
                    // Scan from entry 0 for the first free slot.
                    first_free = -1;
                    for (i = 0; i < ENTRY_COUNT && first_free < 0; i++)
                        if (fat_mirror[i] == MARK_FREE)
                            first_free = i;
                    if (first_free < 0)
                    begin
                        res.status = STAT_FULL;
                    end
                    else
                    begin
                        // Mark first, link second: a self link wins.
                        fat_mirror[first_free] = MARK_END;
                        if (r.link_previous)
                            fat_mirror[idx] = 12'(first_free);
                        res.allocated_index = 12'(first_free);
                    end
                end
            end
            CMD_FREE:
            begin
                if (!in_range)
                begin
                    res.status = STAT_RANGE;
                end
                else
                begin
                    // Free each entry before judging its link; stop on an
                    // end mark (ok) or anything that is not a valid link.
                    res.status = STAT_BROKEN;
                    cur = idx;
                    walking = 1'b1;
                    for (i = 0; i <= ENTRY_COUNT && walking; i++)
                    begin
                        next_link = fat_mirror[cur];
                        fat_mirror[cur] = MARK_FREE;
                        if (next_link >= MARK_END)
                        begin
                            res.status = STAT_OK;
                            walking = 1'b0;
                        end
                        else if (next_link < 12'd2 || int'(next_link) >= ENTRY_COUNT
                                 || next_link >= MARK_RESERVED)
                        begin
                            walking = 1'b0;
                        end
                        else
                        begin
                            cur = int'(next_link);
                        end
                    end
                end
            end
            CMD_PACKED:
            begin
                if (int'(r.byte_offset) < PACKED_BYTES)
                begin
                    pair = int'(r.byte_offset) / 3;
                    lo_e = mirror_entry(2 * pair);
                    hi_e = mirror_entry(2 * pair + 1);
                    case (int'(r.byte_offset) % 3)
                        0:       res.packed_byte = lo_e[11:4];
                        1:       res.packed_byte = {lo_e[3:0], hi_e[11:8]};
                        default: res.packed_byte = hi_e[7:0];
                    endcase
                end
                else
                begin
                    res.status = STAT_RANGE;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: advance the backlog on the request channel
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_ready)
        begin
            // A beat accepted on this edge moves the mirror forward.
            if (req_valid)
                expected_replies = {expected_replies, run_fat_command(req)};
            // Load the next beat unless we idle this cycle.
            if (command_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req       <= command_backlog.pop_front();
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each reply beat with the oldest prediction
    // ------------------------------------------------------------------
    task automatic note_failure(string what, rsp_item_t want, rsp_item_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t %s: expected ev=%h ai=%h pb=%h st=%0d, got ev=%h ai=%h pb=%h st=%0d",
                     $time, what, want.entry_value, want.allocated_index,
                     want.packed_byte, want.status, got.entry_value,
                     got.allocated_index, got.packed_byte, got.status);
    endtask

    always @(posedge clk)
    begin : reply_check
        rsp_item_t want;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    note_failure("reply with nothing pending", '0, rsp);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (rsp.entry_value !== want.entry_value
                        || rsp.allocated_index !== want.allocated_index
                        || rsp.packed_byte !== want.packed_byte
                        || rsp.status !== want.status)
                        note_failure("reply mismatch", want, rsp);
                end
            end
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no beat moves on either channel for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", quiet_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [11:0] any12();
        return 12'($urandom);
    endfunction

    function automatic logic [12:0] any13();
        return 13'($urandom);
    endfunction

    function automatic logic any1();
        return 1'($urandom);
    endfunction

    // Mostly in-range entries, sometimes anything the field holds.
    function automatic logic [11:0] pick_index();
        if ($urandom_range(99) < 80)
            return 12'($urandom_range(ENTRY_COUNT - 1));
        return any12();
    endfunction

    // A link value that must stop a chain walk with a broken-chain status.
    function automatic logic [11:0] broken_link(logic [11:0] loop_back);
        case ($urandom_range(4))
            0:       return MARK_FREE;
            1:       return 12'd1;
            2:       return MARK_RESERVED + 12'($urandom_range(7));
            3:       return 12'($urandom_range(32'hFEF, ENTRY_COUNT));
            default: return loop_back;
        endcase
    endfunction

    task automatic send(logic [2:0] cmd, logic [11:0] idx, logic [11:0] val, logic link,
                        logic [12:0] off);
        req_item_t it;
        it.command       = cmd;
        it.entry_index   = idx;
        it.new_value     = val;
        it.link_previous = link;
        it.byte_offset   = off;
        command_backlog = {command_backlog, it};
        queued_count++;
    endtask

    // Build a chain of distinct entries by writes, optionally with one bad
    // link (free, reserved, out of range or looping back), then optionally free it.
    task automatic queue_chain(int len, bit corrupt, bit release_chain);
        int          nodes [8];
        int          base;
        int          stride;
        int          bad_at;
        int          k;
        logic [11:0] link_val;
        base   = $urandom_range(ENTRY_COUNT - 3);
        stride = $urandom_range(383, 1);
        bad_at = -1;
        if (corrupt)
            bad_at = $urandom_range(len - 1);
        for (k = 0; k < len; k++)
            nodes[k] = 2 + (base + k * stride) % (ENTRY_COUNT - 2);
        for (k = 0; k < len; k++)
        begin
            if (k == bad_at)
                link_val = broken_link(12'(nodes[$urandom_range(k)]));
            else if (k == len - 1)
                link_val = MARK_END + 12'($urandom_range(7));
            else
                link_val = 12'(nodes[k + 1]);
            send(CMD_WRITE, 12'(nodes[k]), link_val, any1(), any13());
        end
        if (release_chain)
            send(CMD_FREE, 12'(nodes[0]), any12(), any1(), any13());
    endtask

    // Make an entry a chain end, extend it by allocate, then free the pair.
    task automatic queue_alloc_extend();
        logic [11:0] head;
        head = 12'($urandom_range(ENTRY_COUNT - 1, 2));
        send(CMD_WRITE, head, MARK_END + 12'($urandom_range(7)), any1(), any13());
        send(CMD_ALLOC, head, any12(), 1'b1, any13());
        if ($urandom_range(3) == 0)
            send(CMD_READ, head, any12(), any1(), any13());
        send(CMD_FREE, head, any12(), any1(), any13());
    endtask

    task automatic queue_random(int count);
        int stop_at;
        int roll;
        stop_at = queued_count + count;
        while (queued_count < stop_at)
        begin
            roll = $urandom_range(99);
            if (roll < 30)
                queue_chain($urandom_range(8, 1), $urandom_range(99) < 20,
                            $urandom_range(99) < 90);
            else if (roll < 45)
                queue_alloc_extend();
            else if (roll < 53)
                send(CMD_READ, pick_index(), any12(), any1(), any13());
            else if (roll < 57)
                send(CMD_READ, 12'($urandom_range(63)), any12(), any1(), any13());
            else if (roll < 63)
                send(CMD_PACKED, any12(), any12(), any1(),
                     13'($urandom_range(PACKED_BYTES - 1)));
            else if (roll < 67)
                send(CMD_PACKED, any12(), any12(), any1(), any13());
            else if (roll < 74)
                send(CMD_WRITE, pick_index(), any12(), any1(), any13());
            else if (roll < 80)
                send(CMD_FREE, pick_index(), any12(), any1(), any13());
            else if (roll < 86)
                send(CMD_ALLOC, pick_index(), any12(), any1(), any13());
            else if (roll < 90)
                send(3'($urandom_range(7, 5)), any12(), any12(), any1(), any13());
            else
                send(CMD_PACKED, any12(), any12(), any1(), 13'($urandom_range(95)));
        end
    endtask

    // Hold until every queued beat went out and every reply came back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (command_backlog.size() != 0 || req_valid || expected_replies.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : sequencer
        int e;
        for (e = 0; e < ENTRY_COUNT; e++)
            fat_mirror[e] = MARK_FREE;
        fat_mirror[0] = MARK_RESERVED;
        fat_mirror[1] = MARK_RESERVED;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Phase one: sender idles rarely, receiver stalls often.
        send_idle_pct = 10;
        recv_idle_pct = 58;

        // Reserved entries, last entry, out-of-range indexes.
        send(CMD_READ, 12'd0, any12(), any1(), any13());
        send(CMD_READ, 12'd1, any12(), any1(), any13());
        send(CMD_READ, 12'(ENTRY_COUNT - 1), any12(), any1(), any13());
        send(CMD_READ, 12'(ENTRY_COUNT), any12(), any1(), any13());
        send(CMD_READ, 12'hFFF, any12(), any1(), any13());
        // Packed image: first bytes, first offset past the end, max.
        send(CMD_PACKED, any12(), any12(), any1(), 13'd0);
        send(CMD_PACKED, any12(), any12(), any1(), 13'd1);
        send(CMD_PACKED, any12(), any12(), any1(), 13'd2);
        send(CMD_PACKED, any12(), any12(), any1(), 13'(PACKED_BYTES));
        send(CMD_PACKED, any12(), any12(), any1(), 13'h1FFF);
        // Write extremes of value and index, then see them back.
        send(CMD_WRITE, 12'(ENTRY_COUNT - 1), 12'hFFF, any1(), any13());
        send(CMD_WRITE, 12'hFFF, 12'h000, any1(), any13());
        send(CMD_PACKED, any12(), any12(), any1(), 13'(PACKED_BYTES - 1));
        send(CMD_FREE, 12'(ENTRY_COUNT - 1), any12(), any1(), any13());
        // Allocate, link a second entry to it, free the two-entry chain.
        send(CMD_ALLOC, any12(), any12(), 1'b0, any13());
        send(CMD_ALLOC, 12'd2, any12(), 1'b1, any13());
        send(CMD_FREE, 12'd2, any12(), any1(), any13());
        // Self link: link entry 2 while it is the first free one.
        send(CMD_ALLOC, 12'd2, any12(), 1'b1, any13());
        send(CMD_FREE, 12'd2, any12(), any1(), any13());
        // Range errors on allocate with link and on free.
        send(CMD_ALLOC, 12'hFFF, any12(), 1'b1, any13());
        send(CMD_FREE, 12'(ENTRY_COUNT), any12(), any1(), any13());
        // Reserved link stops a walk; unknown commands do nothing.
        send(CMD_WRITE, 12'd2, 12'd1, any1(), any13());
        send(CMD_FREE, 12'd2, any12(), any1(), any13());
        send(3'd5, any12(), any12(), any1(), any13());
        send(3'd7, any12(), any12(), any1(), any13());

        queue_random(520);
        wait_drained();

        // Phase two: swap the idling sides. The drain above holds the sender
        // until every reply is in.
        send_idle_pct = 58;
        recv_idle_pct = 10;
        send(3'd6, any12(), any12(), any1(), any13());
        queue_random(520);
        wait_drained();

        // Phase three: no idling. Chain a long run of entries into one file
        // and free it in one walk.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (e = 2; e < LONG_CHAIN + 1; e++)
            send(CMD_WRITE, 12'(e), 12'(e + 1), any1(), any13());
        send(CMD_WRITE, 12'(LONG_CHAIN + 1), MARK_END, any1(), any13());
        send(CMD_FREE, 12'd2, any12(), any1(), any13());
        wait_drained();

        queue_random(520);
        wait_drained();

        // Let any late stray reply show up before judging.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
src/fct_pkg.sv
src/fat12_chain_table_engine.sv
verif/tb_fat12_chain_table_engine.sv
